// File: src/bfdc_pkg.sv
// bfdc_pkg: shared types, widths, register indexes and constants
// of the box-follow drive controller.
// No dependencies; used by box_follow_drive_controller_core.
package bfdc_pkg;

  localparam int PIXEL_BITS_DEF = 10;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int CENTER_W   = 10;
  localparam int DEADBAND_W = 8;
  localparam int GAIN_W     = 24;
  localparam int LIMIT_W    = 18;
  localparam int RATIO_W    = 16;
  localparam int OUT_W      = 19;
  localparam int RUN_CNT_W  = 5;

  localparam int Q16_FRAC    = 16;
  localparam int TURN_SHIFT  = 8;
  localparam int SPEED_SHIFT = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_CENTER_X       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_DEADBAND      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TURN_GAIN            = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TURN_LIMIT           = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN           = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_LIMIT          = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_AREA_TOLERANCE_RATIO = 3'd6;

  localparam logic [CENTER_W-1:0]   RST_IMAGE_CENTER_X       = 10'd320;
  localparam logic [DEADBAND_W-1:0] RST_CENTER_DEADBAND      = 8'd2;
  localparam logic [GAIN_W-1:0]     RST_TURN_GAIN            = 24'd167772;
  localparam logic [LIMIT_W-1:0]    RST_TURN_LIMIT           = 18'd32768;
  localparam logic [GAIN_W-1:0]     RST_SPEED_GAIN           = 24'd503;
  localparam logic [LIMIT_W-1:0]    RST_SPEED_LIMIT          = 18'd19661;
  localparam logic [RATIO_W-1:0]    RST_AREA_TOLERANCE_RATIO = 16'd13107;

  localparam logic CMD_FRAME  = 1'b0;
  localparam logic CMD_BUMPER = 1'b1;

  localparam logic [1:0] BUMP_LEFT   = 2'd0;
  localparam logic [1:0] BUMP_CENTER = 2'd1;
  localparam logic [1:0] BUMP_RIGHT  = 2'd2;

  localparam logic signed [OUT_W-1:0] REV_LINEAR      = -19'sd13107;
  localparam logic signed [OUT_W-1:0] REV_TURN_LEFT   = -19'sd26214;
  localparam logic signed [OUT_W-1:0] REV_TURN_CENTER = -19'sd32768;
  localparam logic signed [OUT_W-1:0] REV_TURN_RIGHT  = 19'sd26214;

  localparam logic [RUN_CNT_W-1:0] RUN_SIDE_LEN   = 5'd16;
  localparam logic [RUN_CNT_W-1:0] RUN_CENTER_LEN = 5'd21;

  typedef enum logic [1:0] {
    KIND_REF,
    KIND_TRACK,
    KIND_RUN
  } item_kind_t;

  typedef enum logic [1:0] {
    RUN_LEFT,
    RUN_CENTER,
    RUN_RIGHT
  } run_side_t;

endpackage

// File: src/box_follow_drive_controller_core.sv
// box_follow_drive_controller_core: pipelined proportional drive controller
// with deadband, saturation and bumper reverse runs.
// Depends on bfdc_pkg.
//
//   channel  | direction | handshake            | beat carries
//   ---------+-----------+----------------------+---------------------------------
//   cfg      | in        | cfg_valid/cfg_ready  | cfg_index, cfg_data
//   in       | in        | in_valid/in_stall    | cmd, box_x, box_width, box_height,
//            |           |                      | bumper_side, bumper_pressed
//   out      | out       | out_valid/out_stall  | linear_cmd, angular_cmd, last
//
// One item per cycle while in_stall is low; a result passes the stage 1 to 6 and output registers.
// The six-stage datapath is set by the chained area, tolerance and gain
// multiplies, with the wide speed product split into two halves.
// A reverse run holds the output register for 16 or 21 beats; the pipeline
// fills behind it and in_stall rises once every stage is occupied.
// Synchronous reset clears control state and loads register defaults;
// in_stall is high during reset. cfg_ready is always high.
module box_follow_drive_controller_core #(
  parameter int PIXEL_BITS = bfdc_pkg::PIXEL_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfdc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bfdc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                cmd,
  input  logic [PIXEL_BITS-1:0]               box_x,
  input  logic [PIXEL_BITS-1:0]               box_width,
  input  logic [PIXEL_BITS-1:0]               box_height,
  input  logic [1:0]                          bumper_side,
  input  logic                                bumper_pressed,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bfdc_pkg::OUT_W-1:0]   linear_cmd,
  output logic signed [bfdc_pkg::OUT_W-1:0]   angular_cmd,
  output logic                                last
);

  localparam int AB     = 2 * PIXEL_BITS;
  localparam int AW     = AB + bfdc_pkg::Q16_FRAC;
  localparam int HB     = (AW + 1) / 2;
  localparam int UB     = AW - HB;
  localparam int CXW    = PIXEL_BITS + 1;
  localparam int LOHI_W = bfdc_pkg::CENTER_W + 1;
  localparam int TW     = ((CXW > LOHI_W) ? CXW : LOHI_W) + 1;
  localparam int TEW    = TW - 1;
  localparam int TPW    = bfdc_pkg::GAIN_W + TEW;
  localparam int TSW    = TPW - bfdc_pkg::TURN_SHIFT;
  localparam int SPL    = bfdc_pkg::GAIN_W + HB;
  localparam int SPH    = bfdc_pkg::GAIN_W + UB;
  localparam int SSW    = SPH + 1;
  localparam int PW     = SSW - (bfdc_pkg::SPEED_SHIFT - HB);

  // configuration registers
  logic [bfdc_pkg::CENTER_W-1:0]   image_center_x;
  logic [bfdc_pkg::DEADBAND_W-1:0] center_deadband;
  logic [bfdc_pkg::GAIN_W-1:0]     turn_gain;
  logic [bfdc_pkg::LIMIT_W-1:0]    turn_limit;
  logic [bfdc_pkg::GAIN_W-1:0]     speed_gain;
  logic [bfdc_pkg::LIMIT_W-1:0]    speed_limit;
  logic [bfdc_pkg::RATIO_W-1:0]    area_tolerance_ratio;

  // controller state
  logic [AB-1:0]   reference_area;
  logic [AW-1:0]   area_tolerance;
  logic [AW:0]     ref_plus_tol;
  logic signed [AW+1:0] ref_minus_tol;
  logic            reference_taken, reference_taken_next;
  logic            avoid_enabled, avoid_enabled_next;
  logic [2:0]      side_flags, side_flags_next;
  logic            reverse_pending, reverse_pending_next;

  logic            in_acc;
  logic [2:0]      side_oh;
  logic            enter;
  bfdc_pkg::item_kind_t enter_kind;
  bfdc_pkg::run_side_t  enter_side;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, out_free;

  // stage 1
  logic v1;
  bfdc_pkg::item_kind_t k1;
  bfdc_pkg::run_side_t  r1;
  logic [PIXEL_BITS-1:0] bx1, bw1, bh1;
  logic [AB-1:0]   area1;
  logic [CXW-1:0]  cx1;
  logic signed [TW-1:0] cx_s, lo_s, hi_s, diff_lo, diff_hi;
  logic            tneg1;
  logic [TEW-1:0]  texc1;

  // stage 2
  logic v2;
  bfdc_pkg::item_kind_t k2;
  bfdc_pkg::run_side_t  r2;
  logic [AB-1:0]   area2;
  logic            tneg2;
  logic [TEW-1:0]  texc2;
  logic [AW-1:0]   tol_prod;
  logic [TPW-1:0]  tprod2;

  // stage 3
  logic v3;
  bfdc_pkg::item_kind_t k3;
  bfdc_pkg::run_side_t  r3;
  logic [AB-1:0]   area3;
  logic            tneg3, lost3;
  logic [TPW-1:0]  tprod3;
  logic [TSW-1:0]  tsh3;
  logic [bfdc_pkg::LIMIT_W-1:0] tmag3;
  logic [AW:0]     rpt_new;
  logic signed [AW+1:0] rmt_new;

  // stage 4
  logic v4;
  bfdc_pkg::item_kind_t k4;
  bfdc_pkg::run_side_t  r4;
  logic [AB-1:0]   area4;
  logic            tneg4, lost4;
  logic [bfdc_pkg::LIMIT_W-1:0] tmag4;
  logic [AW-1:0]   a_q16;
  logic signed [AW+1:0] d_above, d_below;
  logic            sneg4;
  logic [AW-1:0]   sexc4;

  // stage 5
  logic v5;
  bfdc_pkg::item_kind_t k5;
  bfdc_pkg::run_side_t  r5;
  logic            tneg5, lost5, sneg5;
  logic [bfdc_pkg::LIMIT_W-1:0] tmag5;
  logic [AW-1:0]   sexc5;
  logic [SPL-1:0]  plo5;
  logic [SPH-1:0]  phi5;

  // stage 6
  logic v6;
  bfdc_pkg::item_kind_t k6;
  bfdc_pkg::run_side_t  r6;
  logic            tneg6, lost6, sneg6;
  logic [bfdc_pkg::LIMIT_W-1:0] tmag6;
  logic [SPL-1:0]  plo6;
  logic [SPH-1:0]  phi6;
  logic [SSW-1:0]  ssum;
  logic [PW-1:0]   sprod;
  logic [bfdc_pkg::LIMIT_W-1:0] smag;
  logic signed [bfdc_pkg::OUT_W-1:0] s_lin, s_ang;
  logic signed [bfdc_pkg::OUT_W-1:0] o_lin, o_ang;
  logic            o_last;
  logic [bfdc_pkg::RUN_CNT_W-1:0] o_rem;

  // output stage
  logic [bfdc_pkg::RUN_CNT_W-1:0] rem;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_center_x       <= bfdc_pkg::RST_IMAGE_CENTER_X;
      center_deadband      <= bfdc_pkg::RST_CENTER_DEADBAND;
      turn_gain            <= bfdc_pkg::RST_TURN_GAIN;
      turn_limit           <= bfdc_pkg::RST_TURN_LIMIT;
      speed_gain           <= bfdc_pkg::RST_SPEED_GAIN;
      speed_limit          <= bfdc_pkg::RST_SPEED_LIMIT;
      area_tolerance_ratio <= bfdc_pkg::RST_AREA_TOLERANCE_RATIO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bfdc_pkg::CFG_IMAGE_CENTER_X:
          image_center_x <= cfg_data[bfdc_pkg::CENTER_W-1:0];
        bfdc_pkg::CFG_CENTER_DEADBAND:
          center_deadband <= cfg_data[bfdc_pkg::DEADBAND_W-1:0];
        bfdc_pkg::CFG_TURN_GAIN:
          turn_gain <= cfg_data[bfdc_pkg::GAIN_W-1:0];
        bfdc_pkg::CFG_TURN_LIMIT:
          turn_limit <= cfg_data[bfdc_pkg::LIMIT_W-1:0];
        bfdc_pkg::CFG_SPEED_GAIN:
          speed_gain <= cfg_data[bfdc_pkg::GAIN_W-1:0];
        bfdc_pkg::CFG_SPEED_LIMIT:
          speed_limit <= cfg_data[bfdc_pkg::LIMIT_W-1:0];
        bfdc_pkg::CFG_AREA_TOLERANCE_RATIO:
          area_tolerance_ratio <= cfg_data[bfdc_pkg::RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  // stage ready chain
  assign out_free = !out_valid || (!out_stall && last);
  assign rdy6     = !v6 || out_free;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = rst || !rdy1;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    case (bumper_side)
      bfdc_pkg::BUMP_LEFT:   side_oh = 3'b001;
      bfdc_pkg::BUMP_CENTER: side_oh = 3'b010;
      bfdc_pkg::BUMP_RIGHT:  side_oh = 3'b100;
      default:               side_oh = 3'b000;
    endcase
  end

  // classify the beat against current state
  always_comb begin
    side_flags_next      = side_flags;
    reverse_pending_next = reverse_pending;
    avoid_enabled_next   = avoid_enabled;
    reference_taken_next = reference_taken;
    enter                = 1'b0;
    enter_kind           = bfdc_pkg::KIND_TRACK;
    enter_side           = bfdc_pkg::RUN_LEFT;
    if (in_acc) begin
      if (cmd == bfdc_pkg::CMD_BUMPER) begin
        if (bumper_pressed) begin
          avoid_enabled_next = 1'b1;
          if ((side_oh & ~side_flags) != 3'b000) begin
            side_flags_next      = side_flags | side_oh;
            reverse_pending_next = 1'b1;
          end
        end else begin
          side_flags_next = side_flags & ~side_oh;
        end
      end else if (avoid_enabled) begin
        avoid_enabled_next = 1'b0;
        if (reverse_pending && side_flags != 3'b000) begin
          reverse_pending_next = 1'b0;
          enter                = 1'b1;
          enter_kind           = bfdc_pkg::KIND_RUN;
          if (side_flags[0]) begin
            enter_side = bfdc_pkg::RUN_LEFT;
          end else if (side_flags[1]) begin
            enter_side = bfdc_pkg::RUN_CENTER;
          end else begin
            enter_side = bfdc_pkg::RUN_RIGHT;
          end
        end
      end else if (!reference_taken) begin
        reference_taken_next = 1'b1;
        enter                = 1'b1;
        enter_kind           = bfdc_pkg::KIND_REF;
      end else begin
        enter      = 1'b1;
        enter_kind = bfdc_pkg::KIND_TRACK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_flags      <= 3'b000;
      reverse_pending <= 1'b0;
      avoid_enabled   <= 1'b0;
      reference_taken <= 1'b0;
    end else begin
      side_flags      <= side_flags_next;
      reverse_pending <= reverse_pending_next;
      avoid_enabled   <= avoid_enabled_next;
      reference_taken <= reference_taken_next;
    end
  end

  // stage 1: area and horizontal error
  always_comb begin
    area1   = AB'(bw1) * AB'(bh1);
    cx1     = CXW'(bx1) + CXW'(bw1 >> 1);
    cx_s    = signed'(TW'(cx1));
    lo_s    = signed'(TW'(image_center_x)) - signed'(TW'(center_deadband));
    hi_s    = signed'(TW'(image_center_x)) + signed'(TW'(center_deadband));
    diff_lo = lo_s - cx_s;
    diff_hi = cx_s - hi_s;
    tneg1   = 1'b0;
    texc1   = '0;
    if (cx_s <= lo_s) begin
      texc1 = diff_lo[TEW-1:0];
    end else if (cx_s >= hi_s) begin
      tneg1 = 1'b1;
      texc1 = diff_hi[TEW-1:0];
    end
  end

  // stage 2: tolerance and turn products
  assign tol_prod = AW'(area_tolerance_ratio) * AW'(area2);
  assign tprod2   = TPW'(turn_gain) * TPW'(texc2);

  // stage 3: turn saturation, reference bounds
  always_comb begin
    tsh3    = tprod3[TPW-1:bfdc_pkg::TURN_SHIFT];
    tmag3   = (tsh3 >= TSW'(turn_limit)) ? turn_limit : tsh3[bfdc_pkg::LIMIT_W-1:0];
    rpt_new = (AW + 1)'({reference_area, {bfdc_pkg::Q16_FRAC{1'b0}}})
            + (AW + 1)'(area_tolerance);
    rmt_new = signed'((AW + 2)'({reference_area, {bfdc_pkg::Q16_FRAC{1'b0}}}))
            - signed'((AW + 2)'(area_tolerance));
  end

  // stage 4: area error against the reference tolerance band
  always_comb begin
    a_q16   = {area4, {bfdc_pkg::Q16_FRAC{1'b0}}};
    d_above = signed'((AW + 2)'(a_q16)) - signed'((AW + 2)'(ref_plus_tol));
    d_below = ref_minus_tol - signed'((AW + 2)'(a_q16));
    sneg4   = 1'b0;
    sexc4   = '0;
    if (!d_above[AW+1]) begin
      sneg4 = 1'b1;
      sexc4 = d_above[AW-1:0];
    end else if (!d_below[AW+1]) begin
      sexc4 = d_below[AW-1:0];
    end
  end

  // stage 5: split speed product
  assign plo5 = SPL'(speed_gain) * SPL'(sexc5[HB-1:0]);
  assign phi5 = SPH'(speed_gain) * SPH'(sexc5[AW-1:HB]);

  // stage 6: recombine, saturate, pick the result
  always_comb begin
    ssum  = SSW'(phi6) + SSW'(plo6[SPL-1:HB]);
    sprod = ssum[SSW-1:bfdc_pkg::SPEED_SHIFT-HB];
    smag  = (sprod >= PW'(speed_limit)) ? speed_limit
                                         : sprod[bfdc_pkg::LIMIT_W-1:0];
    s_lin = sneg6 ? -signed'(bfdc_pkg::OUT_W'(smag)) : signed'(bfdc_pkg::OUT_W'(smag));
    s_ang = tneg6 ? -signed'(bfdc_pkg::OUT_W'(tmag6)) : signed'(bfdc_pkg::OUT_W'(tmag6));
    o_lin  = s_lin;
    o_ang  = s_ang;
    o_last = 1'b1;
    o_rem  = '0;
    if (k6 == bfdc_pkg::KIND_RUN) begin
      o_lin  = bfdc_pkg::REV_LINEAR;
      o_last = 1'b0;
      case (r6)
        bfdc_pkg::RUN_LEFT: begin
          o_ang = bfdc_pkg::REV_TURN_LEFT;
          o_rem = bfdc_pkg::RUN_SIDE_LEN - 5'd1;
        end
        bfdc_pkg::RUN_CENTER: begin
          o_ang = bfdc_pkg::REV_TURN_CENTER;
          o_rem = bfdc_pkg::RUN_CENTER_LEN - 5'd1;
        end
        default: begin
          o_ang = bfdc_pkg::REV_TURN_RIGHT;
          o_rem = bfdc_pkg::RUN_SIDE_LEN - 5'd1;
        end
      endcase
    end else if (lost6) begin
      o_lin = '0;
      o_ang = '0;
    end
  end

  // valid bits and reference state
  always_ff @(posedge clk) begin
    if (rst) begin
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      v4             <= 1'b0;
      v5             <= 1'b0;
      v6             <= 1'b0;
      reference_area <= '0;
      area_tolerance <= '0;
      ref_plus_tol   <= '0;
      ref_minus_tol  <= '0;
    end else begin
      if (rdy1) v1 <= enter;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
      if (v2 && rdy3 && k2 == bfdc_pkg::KIND_REF) begin
        reference_area <= area2;
        area_tolerance <= tol_prod;
      end
      if (v3 && rdy4 && k3 == bfdc_pkg::KIND_REF) begin
        ref_plus_tol  <= rpt_new;
        ref_minus_tol <= rmt_new;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (in_acc) begin
      k1  <= enter_kind;
      r1  <= enter_side;
      bx1 <= box_x;
      bw1 <= box_width;
      bh1 <= box_height;
    end
    if (rdy2) begin
      k2    <= k1;
      r2    <= r1;
      area2 <= area1;
      tneg2 <= tneg1;
      texc2 <= texc1;
    end
    if (rdy3) begin
      k3     <= k2;
      r3     <= r2;
      area3  <= area2;
      tneg3  <= tneg2;
      tprod3 <= tprod2;
      lost3  <= (area2 == AB'(1));
    end
    if (rdy4) begin
      k4    <= k3;
      r4    <= r3;
      area4 <= area3;
      tneg4 <= tneg3;
      tmag4 <= tmag3;
      lost4 <= lost3;
    end
    if (rdy5) begin
      k5    <= k4;
      r5    <= r4;
      tneg5 <= tneg4;
      tmag5 <= tmag4;
      lost5 <= lost4;
      sneg5 <= sneg4;
      sexc5 <= sexc4;
    end
    if (rdy6) begin
      k6    <= k5;
      r6    <= r5;
      tneg6 <= tneg5;
      tmag6 <= tmag5;
      lost6 <= lost5;
      sneg6 <= sneg5;
      plo6  <= plo5;
      phi6  <= phi5;
    end
  end

  // output register: load a new beat, or advance a reverse run
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last      <= 1'b1;
      rem       <= '0;
    end else if (out_free) begin
      out_valid <= v6 && (k6 != bfdc_pkg::KIND_REF);
      if (v6) begin
        last <= o_last;
        rem  <= o_rem;
      end
    end else if (!out_stall) begin
      rem  <= rem - 5'd1;
      last <= (rem == 5'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && v6) begin
      linear_cmd  <= o_lin;
      angular_cmd <= o_ang;
    end
  end

endmodule

// File: test/testbench.sv
// testbench: self-checking bench for box_follow_drive_controller_core.
// Feeds frame and bumper beats and register writes, predicts every drive command
// in step with the core and checks each result beat; depends on bfdc_pkg.
module testbench;

  localparam int PIX = bfdc_pkg::PIXEL_BITS_DEF;
  localparam int PIX_MAX = (1 << PIX) - 1;
  localparam logic [1:0] BUMP_NONE = 2'd3;
  localparam logic [bfdc_pkg::CFG_INDEX_W-1:0] CFG_UNMAPPED = 3'd7;
  localparam int REF_W = 100;
  localparam int REF_H = 80;
  localparam int SETTLE = 12;

  typedef struct packed {
    logic           cmd;
    logic [PIX-1:0] x;
    logic [PIX-1:0] w;
    logic [PIX-1:0] h;
    logic [1:0]     side;
    logic           pressed;
  } drive_item_t;

  typedef struct packed {
    logic signed [bfdc_pkg::OUT_W-1:0] lin;
    logic signed [bfdc_pkg::OUT_W-1:0] ang;
    logic                              last;
  } drive_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bfdc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [bfdc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic cmd = bfdc_pkg::CMD_FRAME;
  logic [PIX-1:0] box_x = '0;
  logic [PIX-1:0] box_width = '0;
  logic [PIX-1:0] box_height = '0;
  logic [1:0] bumper_side = bfdc_pkg::BUMP_LEFT;
  logic bumper_pressed = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [bfdc_pkg::OUT_W-1:0] linear_cmd;
  logic signed [bfdc_pkg::OUT_W-1:0] angular_cmd;
  logic last;

  logic [bfdc_pkg::CENTER_W-1:0]   ctr_x     = bfdc_pkg::RST_IMAGE_CENTER_X;
  logic [bfdc_pkg::DEADBAND_W-1:0] ctr_band  = bfdc_pkg::RST_CENTER_DEADBAND;
  logic [bfdc_pkg::GAIN_W-1:0]     turn_k    = bfdc_pkg::RST_TURN_GAIN;
  logic [bfdc_pkg::LIMIT_W-1:0]    turn_max  = bfdc_pkg::RST_TURN_LIMIT;
  logic [bfdc_pkg::GAIN_W-1:0]     speed_k   = bfdc_pkg::RST_SPEED_GAIN;
  logic [bfdc_pkg::LIMIT_W-1:0]    speed_max = bfdc_pkg::RST_SPEED_LIMIT;
  logic [bfdc_pkg::RATIO_W-1:0]    tol_ratio = bfdc_pkg::RST_AREA_TOLERANCE_RATIO;

  logic [2*PIX-1:0]                   ref_area    = '0;
  logic [2*PIX+bfdc_pkg::RATIO_W-1:0] tol_q16     = '0;
  logic                               ref_set     = 1'b0;
  logic                               avoid_armed = 1'b0;
  logic                               run_owed    = 1'b0;
  logic [2:0]                         bump_flags  = '0;

  drive_item_t pending_items[$];
  drive_cmd_t  expected_cmds[$];
  drive_item_t cur_item;
  logic in_taken = 1'b0;
  int in_gap = 0;
  int stall_left = 0;
  int send_gap_max = 12;
  int stall_max = 12;
  int beats_queued = 0;
  int beats_in = 0;
  int cmds_seen = 0;
  int reverse_runs = 0;
  int reg_writes = 0;
  int fails = 0;

  box_follow_drive_controller_core #(.PIXEL_BITS(PIX)) i_dut (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic void load_setting(logic [bfdc_pkg::CFG_INDEX_W-1:0] idx,
                                       logic [bfdc_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      bfdc_pkg::CFG_IMAGE_CENTER_X:       ctr_x = val[bfdc_pkg::CENTER_W-1:0];
      bfdc_pkg::CFG_CENTER_DEADBAND:      ctr_band = val[bfdc_pkg::DEADBAND_W-1:0];
      bfdc_pkg::CFG_TURN_GAIN:            turn_k = val[bfdc_pkg::GAIN_W-1:0];
      bfdc_pkg::CFG_TURN_LIMIT:           turn_max = val[bfdc_pkg::LIMIT_W-1:0];
      bfdc_pkg::CFG_SPEED_GAIN:           speed_k = val[bfdc_pkg::GAIN_W-1:0];
      bfdc_pkg::CFG_SPEED_LIMIT:          speed_max = val[bfdc_pkg::LIMIT_W-1:0];
      bfdc_pkg::CFG_AREA_TOLERANCE_RATIO: tol_ratio = val[bfdc_pkg::RATIO_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic longint capped_gain(longint k, longint excess, int shift, longint cap);
    longint p;
    p = (k * excess) >> shift;
    return (p < cap) ? p : cap;
  endfunction

  function automatic void put_cmd(logic signed [bfdc_pkg::OUT_W-1:0] lin,
                                  logic signed [bfdc_pkg::OUT_W-1:0] ang, logic fin);
    drive_cmd_t c;
    c.lin = lin;
    c.ang = ang;
    c.last = fin;
    expected_cmds.push_back(c);
  endfunction

  function automatic void predict_drive(drive_item_t it);
    longint area, cx, lo, hi, a, r, t, turn, speed;
    int n;
    logic signed [bfdc_pkg::OUT_W-1:0] rev_ang;
    n = 0;
    rev_ang = '0;
    if (it.cmd == bfdc_pkg::CMD_BUMPER) begin
      if (it.pressed) begin
        avoid_armed = 1'b1;
        if (it.side != BUMP_NONE && !bump_flags[it.side]) begin
          bump_flags[it.side] = 1'b1;
          run_owed = 1'b1;
        end
      end else if (it.side != BUMP_NONE) begin
        bump_flags[it.side] = 1'b0;
      end
      return;
    end
    if (avoid_armed) begin
      avoid_armed = 1'b0;
      if (bump_flags[bfdc_pkg::BUMP_LEFT]) begin
        n = int'(bfdc_pkg::RUN_SIDE_LEN);
        rev_ang = bfdc_pkg::REV_TURN_LEFT;
      end else if (bump_flags[bfdc_pkg::BUMP_CENTER]) begin
        n = int'(bfdc_pkg::RUN_CENTER_LEN);
        rev_ang = bfdc_pkg::REV_TURN_CENTER;
      end else if (bump_flags[bfdc_pkg::BUMP_RIGHT]) begin
        n = int'(bfdc_pkg::RUN_SIDE_LEN);
        rev_ang = bfdc_pkg::REV_TURN_RIGHT;
      end
      if (n != 0 && run_owed) begin
        for (int k = 0; k < n; k++) put_cmd(bfdc_pkg::REV_LINEAR, rev_ang, k == n - 1);
        run_owed = 1'b0;
        reverse_runs++;
      end
      return;
    end
    area = longint'(it.w) * longint'(it.h);
    if (!ref_set) begin
      t = longint'(tol_ratio) * area;
      ref_area = area[2*PIX-1:0];
      tol_q16 = t[2*PIX+bfdc_pkg::RATIO_W-1:0];
      ref_set = 1'b1;
      return;
    end
    if (area == 1) begin
      put_cmd('0, '0, 1'b1);
      return;
    end
    cx = longint'(it.x) + longint'(it.w >> 1);
    lo = longint'(ctr_x) - longint'(ctr_band);
    hi = longint'(ctr_x) + longint'(ctr_band);
    if (cx > lo && cx < hi) turn = 0;
    else if (cx <= lo)
      turn = capped_gain(longint'(turn_k), lo - cx, bfdc_pkg::TURN_SHIFT,
                         longint'(turn_max));
    else
      turn = -capped_gain(longint'(turn_k), cx - hi, bfdc_pkg::TURN_SHIFT,
                          longint'(turn_max));
    a = area << bfdc_pkg::Q16_FRAC;
    r = longint'(ref_area) << bfdc_pkg::Q16_FRAC;
    t = longint'(tol_q16);
    if (a > r - t && a < r + t) speed = 0;
    else if (a >= r + t)
      speed = -capped_gain(longint'(speed_k), a - r - t, bfdc_pkg::SPEED_SHIFT,
                           longint'(speed_max));
    else
      speed = capped_gain(longint'(speed_k), r - t - a, bfdc_pkg::SPEED_SHIFT,
                          longint'(speed_max));
    put_cmd(speed[bfdc_pkg::OUT_W-1:0], turn[bfdc_pkg::OUT_W-1:0], 1'b1);
  endfunction

  function automatic void add_frame(int x, int w, int h);
    drive_item_t it;
    it.cmd = bfdc_pkg::CMD_FRAME;
    it.x = PIX'(x);
    it.w = PIX'(w);
    it.h = PIX'(h);
    it.side = 2'($urandom_range(0, 3));
    it.pressed = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
    beats_queued++;
  endfunction

  function automatic void add_bump(logic [1:0] side, logic pressed);
    drive_item_t it;
    it.cmd = bfdc_pkg::CMD_BUMPER;
    it.x = PIX'($urandom_range(0, PIX_MAX));
    it.w = PIX'($urandom_range(0, PIX_MAX));
    it.h = PIX'($urandom_range(0, PIX_MAX));
    it.side = side;
    it.pressed = pressed;
    pending_items.push_back(it);
    beats_queued++;
  endfunction

  // aim near the deadband edges; the area band runs from 100x60 to 100x100
  function automatic void add_aimed_frame();
    int w, h, cx, x;
    w = $urandom_range(60, 130);
    h = $urandom_range(40, 140);
    case ($urandom_range(0, 9))
      0: begin
        w = 1;
        h = 1;
      end
      1: begin
        w = REF_W;
        h = 60;
      end
      2: begin
        w = REF_W;
        h = 100;
      end
      default: ;
    endcase
    cx = int'(ctr_x) + int'($urandom_range(0, 2 * ctr_band + 16)) - int'(ctr_band) - 8;
    x = cx - w / 2;
    if (x < 0 || x > PIX_MAX) x = $urandom_range(0, PIX_MAX);
    add_frame(x, w, h);
  endfunction

  task automatic write_reg(logic [bfdc_pkg::CFG_INDEX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= bfdc_pkg::CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    load_setting(idx, bfdc_pkg::CFG_DATA_W'(val));
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_regs(int c, int d, int tg, int tl, int sg, int sl, int ra);
    write_reg(bfdc_pkg::CFG_IMAGE_CENTER_X, c);
    write_reg(bfdc_pkg::CFG_CENTER_DEADBAND, d);
    write_reg(bfdc_pkg::CFG_TURN_GAIN, tg);
    write_reg(bfdc_pkg::CFG_TURN_LIMIT, tl);
    write_reg(bfdc_pkg::CFG_SPEED_GAIN, sg);
    write_reg(bfdc_pkg::CFG_SPEED_LIMIT, sl);
    write_reg(bfdc_pkg::CFG_AREA_TOLERANCE_RATIO, ra);
  endtask

  task automatic drain();
    @(posedge clk);
    while (beats_in != beats_queued || expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  always @(negedge clk) begin : feed_items
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) in_gap = $urandom_range(0, send_gap_max);
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        cur_item = pending_items.pop_front();
        cmd <= cur_item.cmd;
        box_x <= cur_item.x;
        box_width <= cur_item.w;
        box_height <= cur_item.h;
        bumper_side <= cur_item.side;
        bumper_pressed <= cur_item.pressed;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_items
    in_taken <= !rst && in_valid && !in_stall;
    if (!rst && in_valid && !in_stall) begin
      predict_drive(cur_item);
      beats_in++;
    end
  end

  always @(negedge clk) begin : hold_results
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_cmds
    drive_cmd_t want;
    if (!rst && out_valid && !out_stall) begin
      stall_left = $urandom_range(0, stall_max);
      cmds_seen++;
      if (expected_cmds.size() == 0) begin
        $error("drive result with nothing pending: linear_cmd %0d angular_cmd %0d last %0b",
               linear_cmd, angular_cmd, last);
        fails++;
      end else begin
        want = expected_cmds.pop_front();
        if (linear_cmd !== want.lin) begin
          $error("linear_cmd expected %0d actual %0d", want.lin, linear_cmd);
          fails++;
        end
        if (angular_cmd !== want.ang) begin
          $error("angular_cmd expected %0d actual %0d", want.ang, angular_cmd);
          fails++;
        end
        if (last !== want.last) begin
          $error("last expected %0b actual %0b", want.last, last);
          fails++;
        end
      end
    end
  end

  initial begin : stimulus
    int phase_end;
    int pick;
    logic [1:0] s;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_regs(int'(bfdc_pkg::RST_IMAGE_CENTER_X), int'(bfdc_pkg::RST_CENTER_DEADBAND),
               int'(bfdc_pkg::RST_TURN_GAIN), int'(bfdc_pkg::RST_TURN_LIMIT),
               int'(bfdc_pkg::RST_SPEED_GAIN), int'(bfdc_pkg::RST_SPEED_LIMIT), 16384);
    write_reg(CFG_UNMAPPED, 'hABCDEF);

    add_frame(50, REF_W, REF_H);
    add_frame(0, 1, 1);
    add_frame(270, REF_W, REF_H);
    add_frame(267, REF_W, REF_H);
    add_frame(268, REF_W, REF_H);
    add_frame(272, REF_W, REF_H);
    add_frame(270, REF_W, 100);
    add_frame(270, 101, 100);
    add_frame(270, REF_W, 60);
    add_frame(270, REF_W, 59);
    add_frame(PIX_MAX, PIX_MAX, PIX_MAX);
    add_frame(0, 0, 0);
    add_bump(bfdc_pkg::BUMP_LEFT, 1'b1);
    add_frame(270, REF_W, REF_H);
    add_bump(bfdc_pkg::BUMP_LEFT, 1'b0);
    add_bump(bfdc_pkg::BUMP_CENTER, 1'b1);
    add_bump(bfdc_pkg::BUMP_RIGHT, 1'b1);
    add_frame(270, REF_W, REF_H);
    add_bump(bfdc_pkg::BUMP_CENTER, 1'b0);
    add_bump(bfdc_pkg::BUMP_RIGHT, 1'b1);
    add_frame(270, REF_W, REF_H);
    add_bump(bfdc_pkg::BUMP_RIGHT, 1'b0);
    add_bump(BUMP_NONE, 1'b1);
    add_bump(BUMP_NONE, 1'b0);
    add_frame(270, REF_W, REF_H);
    add_bump(bfdc_pkg::BUMP_RIGHT, 1'b1);
    add_frame(270, REF_W, REF_H);
    add_bump(bfdc_pkg::BUMP_RIGHT, 1'b0);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          send_gap_max = 0;
          stall_max = 0;
          write_regs(int'(bfdc_pkg::RST_IMAGE_CENTER_X), int'(bfdc_pkg::RST_CENTER_DEADBAND),
                     int'(bfdc_pkg::RST_TURN_GAIN), int'(bfdc_pkg::RST_TURN_LIMIT),
                     int'(bfdc_pkg::RST_SPEED_GAIN), int'(bfdc_pkg::RST_SPEED_LIMIT),
                     int'(bfdc_pkg::RST_AREA_TOLERANCE_RATIO));
        end
        1: begin
          send_gap_max = 12;
          stall_max = 12;
          write_regs(0, 0, 'hFFFFFF, 131072, 'hFFFFFF, 131072, 65535);
        end
        2: begin
          send_gap_max = 3;
          stall_max = 12;
          write_regs(1023, 255, 0, 0, 0, 0, 0);
        end
        3: begin
          send_gap_max = 12;
          stall_max = 0;
          write_regs(int'($urandom()), int'($urandom()), int'($urandom()), int'($urandom()),
                     int'($urandom()), int'($urandom()), int'($urandom()));
        end
        default: begin
          send_gap_max = 12;
          stall_max = 12;
          write_regs(512, int'($urandom_range(0, 20)), int'($urandom_range(0, 1 << 20)),
                     int'($urandom_range(0, 131072)), int'($urandom_range(0, 4095)),
                     int'($urandom_range(0, 131072)), int'($urandom_range(0, 65535)));
        end
      endcase
      phase_end = beats_queued + 36;
      while (beats_queued < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          add_aimed_frame();
        end else if (pick < 82) begin
          s = ($urandom_range(0, 9) == 0) ? BUMP_NONE : 2'($urandom_range(0, 2));
          add_bump(s, 1'b1);
          if ($urandom_range(0, 3) != 0) add_aimed_frame();
          if ($urandom_range(0, 1) == 1) add_bump(s, 1'b0);
        end else if (pick < 92) begin
          add_frame(int'($urandom_range(0, PIX_MAX)), int'($urandom_range(0, PIX_MAX)),
                    int'($urandom_range(0, PIX_MAX)));
        end else begin
          add_bump(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
        end
      end
      drain();
    end

    $display("run covered %0d input beats over 6 register settings (%0d register writes),",
             beats_in, reg_writes);
    $display("checking %0d drive results including %0d reverse runs", cmds_seen, reverse_runs);
    if (fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
src/bfdc_pkg.sv
src/box_follow_drive_controller_core.sv
test/testbench.sv
